// ===== hw/rtl/epmq_pkg.sv =====
`timescale 1ns / 1ps

package epmq_pkg;

   // Time base and command codes
   localparam logic [31:0] MS_PER_SECOND = 32'd1000;
   localparam logic        CMD_ADD       = 1'b0;
   localparam logic        CMD_SERVE     = 1'b1;

   // Configuration space: one register, selected when address bit 2 is clear
   localparam int          CSR_ADDR_W        = 3;
   localparam logic        REG_SPEECH_ENABLE = 1'b0;

   // One input item
   typedef struct packed {
      logic              cmd;
      logic [15:0]       entry_handle;
      logic signed [7:0] entry_priority;
      logic [15:0]       validity_seconds;
      logic [31:0]       now_ms;
      logic              sink_ready;
   } req_type;

   // One result item
   typedef struct packed {
      logic              spoke;
      logic [15:0]       spoken_handle;
      logic signed [7:0] spoken_priority;
      logic [4:0]        pending_count;
      logic              retry_request;
      logic              add_dropped;
   } rsp_type;

   // One queue slot
   typedef struct packed {
      logic [15:0]       handle;
      logic signed [7:0] priority_val;
      logic [31:0]       expiry;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic item_en;
      logic add;
      logic scan;
      logic shift_mode;
      logic pop;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic pop_take;
   } sts_type;

endpackage

// ===== hw/rtl/expiring_priority_message_queue.sv =====
`timescale 1ns / 1ps
// Sequence: a disabled item goes straight to its report; an enabled item runs an
// optional add, a purge scan over every stored entry, a pop, and a scan that moves
// the entries after the popped one down, through the one-port-each-way slot memory.
// Throughput: one item at a time; busy drops in the cycle the result strobes.
// Reset (synchronous): queue empty, speech_enable 0; the receiver cannot stall.
module expiring_priority_message_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Item channel
   input  logic                                start,
   output logic                                busy,
   input  epmq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output epmq_pkg::rsp_type                   rsp_data,
   // Configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [epmq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   epmq_pkg::cmd_type cmd;
   epmq_pkg::sts_type sts;
   logic              speech_enable_ff;
   logic              speech_enable_in;
   logic              reg_hit;

   // Enable register
   assign reg_hit = (paddr[2] == epmq_pkg::REG_SPEECH_ENABLE);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? {31'd0, speech_enable_ff} : 32'd0;

   always_comb begin
      speech_enable_in = speech_enable_ff;
      if (psel && penable && pwrite && reg_hit) begin
         speech_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speech_enable_ff <= 1'b0;
      end else begin
         speech_enable_ff <= speech_enable_in;
      end
   end

   epmq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_cmd       (req_data.cmd),
      .speech_enable (speech_enable_ff),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy)
   );

   epmq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still working");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_no_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.spoke) |-> (rsp_data.spoken_handle == 16'd0))
      else $error("handle reported without a pop");
`endif

endmodule

// ===== hw/rtl/epmq_ctrl.sv =====
`timescale 1ns / 1ps

module epmq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_cmd,
   input  logic                  speech_enable,
   input  epmq_pkg::sts_type     sts,
   output epmq_pkg::cmd_type     cmd,
   output logic                  busy
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADD   = 3'd1;
   localparam logic [2:0] ST_PURGE = 3'd2;
   localparam logic [2:0] ST_POP   = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Sequencer: add if asked, purge scan, pop, close gap if popped, report; disabled items only report
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               cmd.item_en = speech_enable;
               if (!speech_enable) begin
                  state_in = ST_FIN;
               end else if (req_cmd == epmq_pkg::CMD_ADD) begin
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_PURGE;
               end
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_PURGE;
         end
         ST_PURGE: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = sts.pop_take ? ST_SHIFT : ST_FIN;
         end
         ST_SHIFT: begin
            cmd.scan       = 1'b1;
            cmd.shift_mode = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/epmq_dp.sv =====
`timescale 1ns / 1ps

module epmq_dp #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  epmq_pkg::req_type     req_data,
   input  epmq_pkg::cmd_type     cmd,
   output epmq_pkg::sts_type     sts,
   output logic                  rsp_valid,
   output epmq_pkg::rsp_type     rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // Slot store
   epmq_pkg::entry_type mem [QUEUE_DEPTH];
   epmq_pkg::entry_type mem_q;
   epmq_pkg::entry_type wdata;
   logic                we;
   logic [AW-1:0]       waddr;
   logic [AW-1:0]       raddr;

   epmq_pkg::req_type   req_ff, req_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lim_ff, lim_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       wr_idx_ff, wr_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic signed [7:0]   best_ff, best_in;
   logic [AW-1:0]       sel_idx_ff, sel_idx_in;
   logic [15:0]         sel_handle_ff, sel_handle_in;
   logic signed [7:0]   sel_prio_ff, sel_prio_in;
   logic                en_ff, en_in;
   logic                spoke_ff, spoke_in;
   logic                dropped_ff, dropped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   epmq_pkg::rsp_type   rsp_ff, rsp_in;

   logic                rd_go;
   logic                keep;
   logic                take;
   logic [31:0]         age;
   logic                expired;

   // Wrapping expiry test: expired when expiry lies up to 2^31-1 ms back
   assign age     = req_ff.now_ms - mem_q.expiry;
   assign expired = (age != 32'd0) && !age[31];
   assign keep    = cmd.shift_mode || !expired;
   assign rd_go   = (rd_idx_ff != lim_ff);
   assign raddr   = rd_idx_ff[AW-1:0];
   assign take    = (wr_idx_ff != '0) && req_ff.sink_ready;

   assign sts.scan_done = (rd_idx_ff == lim_ff) && !rd_vld_ff;
   assign sts.pop_take  = take;

   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      lim_in        = lim_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      rd_vld_in     = 1'b0;
      best_in       = best_ff;
      sel_idx_in    = sel_idx_ff;
      sel_handle_in = sel_handle_ff;
      sel_prio_in   = sel_prio_ff;
      en_in         = en_ff;
      spoke_in      = spoke_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      we            = 1'b0;
      waddr         = wr_idx_ff[AW-1:0];
      wdata         = mem_q;

      // Take the item and arm the purge scan
      if (cmd.load) begin
         req_in     = req_data;
         en_in      = cmd.item_en;
         lim_in     = count_ff;
         rd_idx_in  = '0;
         wr_idx_in  = '0;
         best_in    = '0;
         sel_idx_in = '0;
         spoke_in   = 1'b0;
         dropped_in = 1'b0;
      end

      // Append the new entry unless full
      if (cmd.add) begin
         if (count_ff != DEPTH_C) begin
            we           = 1'b1;
            waddr        = count_ff[AW-1:0];
            wdata.handle = req_ff.entry_handle;
            wdata.priority_val = req_ff.entry_priority;
            wdata.expiry = req_ff.now_ms + 32'(req_ff.validity_seconds)
                           * epmq_pkg::MS_PER_SECOND;
            count_in     = count_ff + 1'b1;
            lim_in       = count_ff + 1'b1;
         end else begin
            dropped_in   = 1'b1;
         end
      end

      // Streaming copy: read ahead, write kept entries down
      if (cmd.scan) begin
         if (rd_go) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         rd_vld_in = rd_go;
         if (rd_vld_ff && keep) begin
            we        = 1'b1;
            waddr     = wr_idx_ff[AW-1:0];
            wdata     = mem_q;
            wr_idx_in = wr_idx_ff + 1'b1;
            // Earliest highest priority above zero, else the first entry
            if (!cmd.shift_mode) begin
               if (mem_q.priority_val > best_ff) begin
                  best_in       = mem_q.priority_val;
                  sel_idx_in    = wr_idx_ff[AW-1:0];
                  sel_handle_in = mem_q.handle;
                  sel_prio_in   = mem_q.priority_val;
               end else if (wr_idx_ff == '0) begin
                  sel_idx_in    = '0;
                  sel_handle_in = mem_q.handle;
                  sel_prio_in   = mem_q.priority_val;
               end
            end
         end
      end

      // Settle the count and arm the gap-closing scan
      if (cmd.pop) begin
         lim_in    = wr_idx_ff;
         count_in  = wr_idx_ff - CW'(take);
         spoke_in  = take;
         rd_idx_in = CW'(sel_idx_ff) + 1'b1;
         wr_idx_in = CW'(sel_idx_ff);
      end

      // Report
      if (cmd.finish) begin
         rsp_valid_in           = 1'b1;
         rsp_in.spoke           = spoke_ff;
         rsp_in.spoken_handle   = spoke_ff ? sel_handle_ff : 16'd0;
         rsp_in.spoken_priority = spoke_ff ? sel_prio_ff : 8'sd0;
         rsp_in.pending_count   = 5'(count_ff);
         rsp_in.retry_request   = en_ff && (count_ff != '0);
         rsp_in.add_dropped     = dropped_ff;
      end
   end

   // Slot memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      mem_q <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      lim_ff        <= lim_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      best_ff       <= best_in;
      sel_idx_ff    <= sel_idx_in;
      sel_handle_ff <= sel_handle_in;
      sel_prio_ff   <= sel_prio_in;
      en_ff         <= en_in;
      spoke_ff      <= spoke_in;
      dropped_ff    <= dropped_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
